// File: rtl/dff_pkg.sv
// Shared widths, character codes and the queued field record of the decimal field formatter.
`timescale 1ns / 1ps
package dff_pkg;

	localparam int MAX_DIGITS_DEF  = 10;
	localparam int NUMBER_BITS_DEF = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam int NUMBER_W = 32;
	localparam int COUNT_W  = 4;
	localparam int COLUMN_W = 8;
	localparam int PAGE_W   = 3;
	localparam int CHAR_W   = 6;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'h20;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'h30;

	localparam logic [COLUMN_W-1:0] STEP_LARGE = 8'd8;
	localparam logic [COLUMN_W-1:0] STEP_SMALL = 8'd6;

	// Everything of a field except its digits
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [COLUMN_W-1:0] column;
		logic [PAGE_W-1:0]   page;
		logic                large_font;
	} field_meta_t;

endpackage

// File: rtl/decimal_field_formatter_core.sv
// Top level of the decimal field formatter: front end, field queue and back end.
`timescale 1ns / 1ps
// Turns an unsigned number into a right-aligned decimal field of digit_count characters
// (clamped to MAX_DIGITS; a count of zero is accepted and yields nothing), most
// significant position first, leading zeros shown as spaces and the last position always a
// digit. Digits above the field length are dropped. The front end converts with a bit-serial
// double dabble shifter and takes no new number until the converted field is pushed; the
// back end emits the characters of one field at a time and stalls on out_ready. A two-entry
// queue between them lets conversion of the next number overlap emission.
module decimal_field_formatter_core import dff_pkg::*; #(
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [NUMBER_W-1:0] number,
	input  logic [COUNT_W-1:0]  digit_count,
	input  logic [COLUMN_W-1:0] start_column,
	input  logic [PAGE_W-1:0]   page,
	input  logic                large_font,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHAR_W-1:0]   char_code,
	output logic [COLUMN_W-1:0] column,
	output logic [PAGE_W-1:0]   row_page,
	output logic                font_large,
	output logic                last
);

	localparam int BCD_W = 4 * MAX_DIGITS;
	localparam int REC_W = BCD_W + $bits(field_meta_t);

	logic              push;
	logic [BCD_W-1:0]  push_bcd;
	field_meta_t       push_meta;
	logic              full;
	logic              pop;
	logic              empty;
	logic [REC_W-1:0]  rdata;
	logic [BCD_W-1:0]  rd_bcd;
	field_meta_t       rd_meta;

	assign rd_bcd  = rdata[REC_W-1 -: BCD_W];
	assign rd_meta = rdata[$bits(field_meta_t)-1:0];

	dff_front #(
		.MAX_DIGITS  (MAX_DIGITS),
		.NUMBER_BITS (NUMBER_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.number       (number),
		.digit_count  (digit_count),
		.start_column (start_column),
		.page         (page),
		.large_font   (large_font),
		.push         (push),
		.push_bcd     (push_bcd),
		.push_meta    (push_meta),
		.full         (full)
	);

	dff_queue #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_bcd, push_meta}),
		.full   (full),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	dff_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.rd_bcd     (rd_bcd),
		.rd_meta    (rd_meta),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.char_code  (char_code),
		.column     (column),
		.row_page   (row_page),
		.font_large (font_large),
		.last       (last)
	);

endmodule

// File: rtl/dff_front.sv
// Front end: accepts numbers, clamps the field length and converts to BCD one bit a cycle.
`timescale 1ns / 1ps
module dff_front import dff_pkg::*; #(
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [NUMBER_W-1:0]     number,
	input  logic [COUNT_W-1:0]      digit_count,
	input  logic [COLUMN_W-1:0]     start_column,
	input  logic [PAGE_W-1:0]       page,
	input  logic                    large_font,
	output logic                    push,
	output logic [4*MAX_DIGITS-1:0] push_bcd,
	output field_meta_t             push_meta,
	input  logic                    full
);

	localparam int BCD_W  = 4 * MAX_DIGITS;
	localparam int STEP_W = $clog2(NUMBER_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_PUSH = 3'b100
	} front_state_t;

	function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
		return (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

	front_state_t            state_q;
	logic [NUMBER_BITS-1:0]  sh_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [BCD_W-1:0]        bcd_adj;
	logic [STEP_W-1:0]       step_q;
	field_meta_t             meta_q;
	logic [COUNT_W-1:0]      count_clamped;
	logic                    accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign push     = (state_q == ST_PUSH) && !full;
	assign push_bcd  = bcd_q;
	assign push_meta = meta_q;

	assign count_clamped = (digit_count > COUNT_W'(MAX_DIGITS)) ?
		COUNT_W'(MAX_DIGITS) : digit_count;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = bcd_adjust(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// drop empty fields here, they produce no characters
					if (accept && count_clamped != '0) state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (step_q == '0) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Double dabble: digits above MAX_DIGITS wrap off the top nibble (value mod 10^MAX_DIGITS)
	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q   <= number[NUMBER_BITS-1:0];
			bcd_q  <= '0;
			step_q <= STEP_W'(NUMBER_BITS - 1);
			meta_q <= '{count: count_clamped, column: start_column, page: page,
				large_font: large_font};
		end else if (state_q == ST_CONV) begin
			sh_q   <= {sh_q[NUMBER_BITS-2:0], 1'b0};
			bcd_q  <= {bcd_adj[BCD_W-2:0], sh_q[NUMBER_BITS-1]};
			step_q <= step_q - STEP_W'(1);
		end
	end

endmodule

// File: rtl/dff_queue.sv
// Small register queue that holds converted fields between front and back end.
`timescale 1ns / 1ps
module dff_queue import dff_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= wdata;
	end

endmodule

// File: rtl/dff_back.sv
// Back end: walks one field from its top position, blanks leading zeros, emits characters.
`timescale 1ns / 1ps
module dff_back import dff_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    empty,
	input  logic [4*MAX_DIGITS-1:0] rd_bcd,
	input  field_meta_t             rd_meta,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CHAR_W-1:0]       char_code,
	output logic [COLUMN_W-1:0]     column,
	output logic [PAGE_W-1:0]       row_page,
	output logic                    font_large,
	output logic                    last
);

	localparam int BCD_W = 4 * MAX_DIGITS;
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic                busy_q;
	logic [IDX_W-1:0]    idx_q;
	logic [COLUMN_W-1:0] col_q;
	logic                shown_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [PAGE_W-1:0]   page_q;
	logic                large_q;

	logic                valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic [COLUMN_W-1:0] column_q;
	logic [PAGE_W-1:0]   out_page_q;
	logic                font_q;
	logic                last_q;

	logic                emit;
	logic [3:0]          digit;
	logic                blank;
	logic [CHAR_W-1:0]   char_next;
	logic [COLUMN_W-1:0] step;

	assign pop  = !busy_q && !empty;
	assign emit = busy_q && (!valid_q || out_ready);

	assign digit     = bcd_q[{idx_q, 2'b00} +: 4];
	assign blank     = !shown_q && (idx_q != '0) && (digit == 4'd0);
	assign char_next = blank ? CHAR_SPACE : (CHAR_ZERO | {2'b00, digit});
	assign step      = large_q ? STEP_LARGE : STEP_SMALL;

	assign out_valid  = valid_q;
	assign char_code  = char_q;
	assign column     = column_q;
	assign row_page   = out_page_q;
	assign font_large = font_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && idx_q == '0) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q   <= IDX_W'(rd_meta.count - COUNT_W'(1));
			col_q   <= rd_meta.column;
			shown_q <= 1'b0;
			bcd_q   <= rd_bcd;
			page_q  <= rd_meta.page;
			large_q <= rd_meta.large_font;
		end else if (emit) begin
			idx_q   <= idx_q - IDX_W'(1);
			col_q   <= col_q + step;
			shown_q <= shown_q || !blank;
		end
		if (emit) begin
			char_q     <= char_next;
			column_q   <= col_q;
			out_page_q <= page_q;
			font_q     <= large_q;
			last_q     <= (idx_q == '0);
		end
	end

	a_last_shows_digit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && last_q |-> char_q != CHAR_SPACE)
		else $error("final character of a field is blank");

	a_field_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ready && !last_q |=> valid_q)
		else $error("gap inside a field");

	a_column_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ready && !last_q |=>
			column_q == $past(column_q) + ($past(font_q) ? STEP_LARGE : STEP_SMALL))
		else $error("column did not advance by the font step");

	a_no_blank_after_digit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_ready && !last_q && char_q != CHAR_SPACE |=> char_q != CHAR_SPACE)
		else $error("blank after a shown digit");

endmodule

// File: bench/decimal_field_formatter_core_test.sv
// Self-checking testbench for the decimal field formatter core.
`timescale 1ns / 1ps
module decimal_field_formatter_core_test import dff_pkg::*;;

	localparam int FIELD_MAX   = 10;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 120;

	typedef enum int {READY_ALWAYS, READY_RANDOM, READY_LONG_STALL} ready_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0]   char_code;
		logic [COLUMN_W-1:0] column;
		logic [PAGE_W-1:0]   row_page;
		logic                font_large;
		logic                last;
	} glyph_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [NUMBER_W-1:0] number = '0;
	logic [COUNT_W-1:0]  digit_count = '0;
	logic [COLUMN_W-1:0] start_column = '0;
	logic [PAGE_W-1:0]   page = '0;
	logic                large_font = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [CHAR_W-1:0]   char_code;
	logic [COLUMN_W-1:0] column;
	logic [PAGE_W-1:0]   row_page;
	logic                font_large;
	logic                last;

	glyph_t      pending_glyphs[$];
	int          error_count = 0;
	int          numbers_sent = 0;
	int          glyphs_checked = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int          stall_left = 0;
	int          gap_max = 0;
	int          burst_max = 0;
	int          burst_left = 0;

	decimal_field_formatter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.number(number),
		.digit_count(digit_count),
		.start_column(start_column),
		.page(page),
		.large_font(large_font),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code),
		.column(column),
		.row_page(row_page),
		.font_large(font_large),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("decimal_field_formatter_core test failed");
		$finish;
	end

	// Expected characters of one field, most significant position first
	function automatic void format_field(logic [NUMBER_W-1:0] value, logic [COUNT_W-1:0] count,
			logic [COLUMN_W-1:0] col, logic [PAGE_W-1:0] pg, logic lg);
		longint unsigned divisor;
		int              positions;
		int              digit;
		bit              shown;
		glyph_t          g;
		logic [COLUMN_W-1:0] step;
		positions = (count > FIELD_MAX) ? FIELD_MAX : count;
		step = lg ? STEP_LARGE : STEP_SMALL;
		shown = 0;
		divisor = 1;
		for (int i = 1; i < positions; i++)
			divisor = divisor * 10;
		for (int t = 0; t < positions; t++) begin
			digit = int'((longint'(value) / divisor) % 10);
			g.last = (t + 1 == positions);
			if (!shown && !g.last && digit == 0) begin
				g.char_code = CHAR_SPACE;
			end else begin
				shown = 1;
				g.char_code = CHAR_ZERO + CHAR_W'(digit);
			end
			g.column = col + step * COLUMN_W'(t);
			g.row_page = pg;
			g.font_large = lg;
			pending_glyphs.push_back(g);
			divisor = divisor / 10;
		end
	endfunction

	// Hold the number until transfer, then open a gap once the burst runs out
	task automatic send_number(logic [NUMBER_W-1:0] value, logic [COUNT_W-1:0] count,
			logic [COLUMN_W-1:0] col, logic [PAGE_W-1:0] pg, logic lg);
		int gap;
		in_valid <= 1'b1;
		number <= value;
		digit_count <= count;
		start_column <= col;
		page <= pg;
		large_font <= lg;
		do
			@(posedge clk);
		while (!in_ready);
		format_field(value, count, col, pg, lg);
		numbers_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else if (gap_max > 0) begin
			gap = $urandom_range(1, gap_max);
			burst_left = $urandom_range(0, burst_max);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return COUNT_W'($urandom_range(11, 15));
		else
			return COUNT_W'($urandom_range(1, FIELD_MAX));
	endfunction

	function automatic logic [NUMBER_W-1:0] pick_number();
		longint unsigned p;
		int k;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(0, 31);
			2: begin
				k = $urandom_range(0, 9);
				p = 1;
				for (int i = 0; i < k; i++)
					p = p * 10;
				return NUMBER_W'(p - $urandom_range(0, 1));
			end
			default: return NUMBER_W'($urandom_range(0, 99));
		endcase
	endfunction

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_number(pick_number(), pick_count(), COLUMN_W'($urandom),
				PAGE_W'($urandom), 1'($urandom));
	endtask

	task automatic test_directed();
		ready_mode = READY_RANDOM;
		gap_max = 3;
		burst_max = 2;
		send_number(32'd0, 4'd1, 8'd0, 3'd0, 1'b0);
		send_number(32'd0, 4'd10, 8'd10, 3'd7, 1'b1);
		send_number(32'hFFFF_FFFF, 4'd10, 8'd255, 3'd5, 1'b1);
		send_number(32'hFFFF_FFFF, 4'd15, 8'd200, 3'd2, 1'b0);
		send_number(32'd123456, 4'd3, 8'd1, 3'd1, 1'b0);
		send_number(32'd1000, 4'd3, 8'd64, 3'd3, 1'b1);
		send_number(32'd1002, 4'd6, 8'd250, 3'd4, 1'b0);
		send_number(32'd7, 4'd0, 8'd12, 3'd6, 1'b1);
		send_number(32'd42, 4'd11, 8'd128, 3'd0, 1'b1);
		send_number(32'd1_000_000_000, 4'd10, 8'd0, 3'd7, 1'b0);
		send_number(32'd999_999_999, 4'd9, 8'd240, 3'd1, 1'b1);
		send_number(32'd5, 4'd1, 8'd255, 3'd2, 1'b1);
		send_number(32'd10, 4'd2, 8'd254, 3'd3, 1'b0);
		send_number(32'h8000_0000, 4'd10, 8'd170, 3'd5, 1'b0);
		send_number(32'd0, 4'd0, 8'd255, 3'd7, 1'b0);
		send_number(32'd9, 4'd8, 8'd85, 3'd6, 1'b1);
		send_number(32'd12345, 4'd5, 8'd0, 3'd4, 1'b0);
		send_number(32'h5555_5555, 4'd12, 8'h55, 3'd5, 1'b1);
		send_number(32'hAAAA_AAAA, 4'd7, 8'hAA, 3'd2, 1'b0);
		send_number(32'd100, 4'd4, 8'd100, 3'd1, 1'b1);
	endtask

	task automatic test_random_fields();
		ready_mode = READY_RANDOM;
		gap_max = 40;
		burst_max = 4;
		send_random(200);
	endtask

	task automatic test_full_rate();
		ready_mode = READY_ALWAYS;
		gap_max = 0;
		burst_left = 0;
		send_random(150);
	endtask

	task automatic test_long_stalls();
		ready_mode = READY_LONG_STALL;
		gap_max = 8;
		burst_max = 6;
		send_random(130);
	endtask

	always @(posedge clk) begin
		case (ready_mode)
			READY_ALWAYS: out_ready <= 1'b1;
			READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(1, 12);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	function automatic void compare_field(string name, int expected, int actual);
		if (expected != actual) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expected, actual);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_glyphs.size() == 0) begin
				$display("%0t: unexpected transfer: expected none, actual char %0h column %0h",
					$time, char_code, column);
				error_count++;
			end else begin
				want = pending_glyphs.pop_front();
				compare_field("char_code", int'(want.char_code), int'(char_code));
				compare_field("column", int'(want.column), int'(column));
				compare_field("row_page", int'(want.row_page), int'(row_page));
				compare_field("font_large", int'(want.font_large), int'(font_large));
				compare_field("last", int'(want.last), int'(last));
				glyphs_checked++;
			end
		end
	end

	initial begin
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random_fields();
		test_full_rate();
		test_long_stalls();
		in_valid <= 1'b0;
		waited = 0;
		while (pending_glyphs.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_glyphs.size() != 0) begin
			$display("%0t: missing transfers: expected %0d more, actual 0", $time,
				pending_glyphs.size());
			error_count++;
		end
		// Give any stray output, such as from a zero-length field, time to show
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d numbers (lengths 0 to 15, both fonts, column wrap), checked %0d chars",
			numbers_sent, glyphs_checked);
		$display("Output side ran always ready, random stalls and long stalls; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("decimal_field_formatter_core test passed");
		else
			$display("decimal_field_formatter_core test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/dff_pkg.sv
rtl/dff_front.sv
rtl/dff_queue.sv
rtl/dff_back.sv
rtl/decimal_field_formatter_core.sv
bench/decimal_field_formatter_core_test.sv
